>>> rtl/thermal_fan_speed_stepper_macros.svh
// Assertion macros shared by the checker of the fan speed stepper.
// No dependencies; the checker takes this header by include.
`ifndef THERMAL_FAN_SPEED_STEPPER_MACROS_SVH
`define THERMAL_FAN_SPEED_STEPPER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TFSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define TFSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tfss_pkg.sv
// Types and constants of the thermal fan speed stepper.
// No dependencies; every other RTL module imports this package.
package tfss_pkg;

   localparam int TEMP_W  = 8;
   localparam int DUTY_W  = 8;
   localparam int LIMIT_W = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DUTY_W-1:0]  DUTY_RESET = 8'h80;
   localparam logic [DUTY_W-1:0]  DUTY_MAX   = 8'hFF;
   localparam logic [DUTY_W-1:0]  DUTY_MIN   = 8'h55;
   localparam logic [DUTY_W-1:0]  DUTY_HOT   = 8'hF8;
   localparam logic [DUTY_W-1:0]  STEP_UP    = 8'd5;
   localparam logic [DUTY_W-1:0]  STEP_DOWN  = 8'd4;
   localparam logic [TEMP_W-1:0]  HOT_TEMP   = 8'd80;
   localparam logic [TEMP_W:0]    HOLD_BAND  = 9'd2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd65;

   // Word index of the only register, taken from paddr[2].
   localparam logic REG_TEMP_LIMIT = 1'b0;

   typedef struct packed {
      logic [TEMP_W-1:0] cpu_temp;
      logic [TEMP_W-1:0] gpu_temp;
   } item_type;

   typedef struct packed {
      logic [DUTY_W-1:0] fan_duty;
      logic              beep;
      logic              overheat;
   } result_type;

   typedef struct packed {
      logic advance;   // the held item is processed at this edge
   } core_ctrl_type;

   typedef struct packed {
      logic emit;      // the held item yields a result
   } core_status_type;

endpackage

>>> rtl/tfss_csr.sv
// Configuration register block of the fan speed stepper: temp_limit.
// Depends on tfss_pkg.
module tfss_csr
   import tfss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LIMIT_W-1:0]    temp_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic               wr_hit;

   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_TEMP_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (wr_hit) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_TEMP_LIMIT) begin
         csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign temp_limit = limit_ff;

endmodule

>>> rtl/tfss_core.sv
// Decision logic and fan state (duty level, warned flag) of the stepper.
// Depends on tfss_pkg.
module tfss_core
   import tfss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  core_ctrl_type      ctrl,
   input  item_type           item,
   input  logic [LIMIT_W-1:0] temp_limit,
   output core_status_type    status,
   output result_type         result
);

   logic [DUTY_W-1:0] duty_ff;
   logic [DUTY_W-1:0] duty_in;
   logic              warned_ff;
   logic              warned_in;

   logic [TEMP_W-1:0] hottest;
   logic [TEMP_W-1:0] limit_ext;
   logic [DUTY_W:0]   raised;
   logic              above;
   logic              hot;
   logic              hold;

   assign hottest   = (item.gpu_temp > item.cpu_temp) ? item.gpu_temp : item.cpu_temp;
   assign limit_ext = {1'b0, temp_limit};
   assign above     = hottest > limit_ext;
   assign hot       = hottest >= HOT_TEMP;
   // Inside the hold band when limit - 2 <= t <= limit; written as t + 2 >= limit so
   // that a limit below two never wraps.
   assign hold      = !above && (({1'b0, hottest} + HOLD_BAND) >= {1'b0, limit_ext});
   assign raised    = {1'b0, duty_ff} + {1'b0, STEP_UP};

   always_comb begin
      duty_in         = duty_ff;
      warned_in       = warned_ff;
      result.beep     = 1'b0;
      result.overheat = 1'b0;
      priority if (above && !hot) begin
         warned_in = 1'b0;
         duty_in   = raised[DUTY_W] ? DUTY_MAX : raised[DUTY_W-1:0];
      end else if (hold) begin
         duty_in   = duty_ff;
      end else if (!above) begin
         warned_in = 1'b0;
         duty_in   = (duty_ff < (DUTY_MIN + STEP_DOWN)) ? DUTY_MIN : (duty_ff - STEP_DOWN);
      end else begin
         result.beep     = !warned_ff;
         result.overheat = 1'b1;
         warned_in       = 1'b1;
         duty_in         = DUTY_HOT;
      end
      result.fan_duty = duty_in;
   end

   assign status.emit = !hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff   <= DUTY_RESET;
         warned_ff <= 1'b0;
      end else if (ctrl.advance) begin
         duty_ff   <= duty_in;
         warned_ff <= warned_in;
      end
   end

endmodule

>>> rtl/thermal_fan_speed_stepper.sv
// An accepted item waits in the input register; when the result register is free
// or drains, its result moves there and is shown (an item in the hold band yields none).
// Throughput: one item per cycle; ready falls only while an item is held and
// the result register is full and not taken.
// Reset is synchronous and active high: both registers empty, duty 128,
// warning clear, temp_limit 65. No clearing pass is needed.
module thermal_fan_speed_stepper
   import tfss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TEMP_W-1:0]     req_cpu_temp,
   input  logic [TEMP_W-1:0]     req_gpu_temp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DUTY_W-1:0]     rsp_fan_duty,
   output logic                  rsp_beep,
   output logic                  rsp_overheat,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic               in_valid_ff;
   logic               in_valid_in;
   item_type           in_item_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   result_type         out_result_ff;
   logic [LIMIT_W-1:0] temp_limit;
   core_ctrl_type      ctrl;
   core_status_type    status;
   result_type         result;
   logic               accept;

   tfss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .temp_limit  (temp_limit)
   );

   tfss_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .item       (in_item_ff),
      .temp_limit (temp_limit),
      .status     (status),
      .result     (result)
   );

   // The held item moves on whenever the result register is free or drains now.
   assign ctrl.advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || ctrl.advance;
   assign accept       = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (ctrl.advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (ctrl.advance) begin
         out_valid_in = status.emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.cpu_temp <= req_cpu_temp;
         in_item_ff.gpu_temp <= req_gpu_temp;
      end
      if (ctrl.advance && status.emit) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_fan_duty = out_result_ff.fan_duty;
   assign rsp_beep     = out_result_ff.beep;
   assign rsp_overheat = out_result_ff.overheat;

endmodule

>>> rtl/tfss_checker.sv
// Port-level checker of the fan speed stepper and its bind to the top level.
// Depends on tfss_pkg and thermal_fan_speed_stepper_macros.svh.
`include "thermal_fan_speed_stepper_macros.svh"

module tfss_checker
   import tfss_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DUTY_W-1:0] rsp_fan_duty,
   input logic              rsp_beep,
   input logic              rsp_overheat
);

   `TFSS_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result after reset")
   `TFSS_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fan_duty) && $stable(rsp_beep) && $stable(rsp_overheat), "stalled result changed")
   `TFSS_ASSERT(a_beep_needs_hot, clock, reset, rsp_valid && rsp_beep |-> rsp_overheat, "beep without overheat")
   `TFSS_ASSERT(a_hot_duty, clock, reset, rsp_valid && rsp_overheat |-> rsp_fan_duty == DUTY_HOT, "overheat duty wrong")
   `TFSS_ASSERT(a_duty_floor, clock, reset, rsp_valid |-> rsp_fan_duty >= DUTY_MIN, "duty below floor")

endmodule

bind thermal_fan_speed_stepper tfss_checker u_tfss_checker (.*);

>>> verif/tb.sv
// Self-checking testbench of the thermal fan speed stepper.
// Depends on tfss_pkg and the thermal_fan_speed_stepper RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tfss_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_TEMP_LIMIT);
   localparam int PHASE_COUNT = 14;
   localparam int PHASE_ITEMS = 110;
   localparam int SETTLE_CYCLES = 5;

   // Keeps its own copy of the limit, the duty and the warning flag, and the
   // fan commands still to come from the block.
   class fan_command_board;
      int unsigned temp_limit;
      int unsigned duty_level;
      bit warned;
      result_type fan_commands[$];
      int fail_count;

      function new();
         temp_limit = LIMIT_RESET;
         duty_level = DUTY_RESET;
         warned = 1'b0;
         fail_count = 0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      function void set_limit(int unsigned value);
         temp_limit = value & ((1 << LIMIT_W) - 1);
      endfunction

      // Works out the fan command, if any, that one accepted item causes.
      function void predict_fan_command(logic [TEMP_W-1:0] cpu, logic [TEMP_W-1:0] gpu);
         int hottest;
         int lim;
         result_type cmd;
         hottest = (gpu > cpu) ? int'(gpu) : int'(cpu);
         lim = int'(temp_limit);
         cmd.beep = 1'b0;
         cmd.overheat = 1'b0;
         if (hottest > lim && hottest < int'(HOT_TEMP)) begin
            warned = 1'b0;
            duty_level = duty_level + STEP_UP;
            if (duty_level > DUTY_MAX) duty_level = DUTY_MAX;
         end else if (hottest <= lim) begin
            // The hold band may start below zero, so the compare stays signed.
            if (hottest >= lim - int'(HOLD_BAND)) return;
            warned = 1'b0;
            if (duty_level < DUTY_MIN + STEP_DOWN) duty_level = DUTY_MIN;
            else duty_level = duty_level - STEP_DOWN;
         end else begin
            cmd.beep = !warned;
            warned = 1'b1;
            cmd.overheat = 1'b1;
            duty_level = DUTY_HOT;
         end
         cmd.fan_duty = duty_level[DUTY_W-1:0];
         fan_commands.push_back(cmd);
      endfunction

      task check_fan_command(logic [DUTY_W-1:0] duty, logic beep, logic overheat);
         result_type want;
         if (fan_commands.size() == 0) begin
            report_mismatch($sformatf("fan command %0d/%b/%b with nothing expected",
                                      duty, beep, overheat));
         end else begin
            want = fan_commands.pop_front();
            if (duty !== want.fan_duty)
               report_mismatch($sformatf("fan_duty %0d, expected %0d", duty, want.fan_duty));
            if (beep !== want.beep)
               report_mismatch($sformatf("beep %b, expected %b", beep, want.beep));
            if (overheat !== want.overheat)
               report_mismatch($sformatf("overheat %b, expected %b", overheat,
                                         want.overheat));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [TEMP_W-1:0] req_cpu_temp = '0;
   logic [TEMP_W-1:0] req_gpu_temp = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DUTY_W-1:0] rsp_fan_duty;
   logic rsp_beep;
   logic rsp_overheat;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bit idle_on = 1'b0;
   int stall_left = 0;
   fan_command_board board = new();

   thermal_fan_speed_stepper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cpu_temp(req_cpu_temp), .req_gpu_temp(req_gpu_temp),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_fan_duty(rsp_fan_duty), .rsp_beep(rsp_beep), .rsp_overheat(rsp_overheat),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both handshakes are seen here with the values from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.predict_fan_command(req_cpu_temp, req_gpu_temp);
         if (rsp_valid && rsp_ready)
            board.check_fan_command(rsp_fan_duty, rsp_beep, rsp_overheat);
      end
   end

   // The receiver stalls in bursts while idling is on.
   always @(posedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 13);
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task send_item(logic [TEMP_W-1:0] cpu, logic [TEMP_W-1:0] gpu);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cpu_temp <= cpu;
      req_gpu_temp <= gpu;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
   endtask

   // Holds the sender off until every expected fan command has come, then
   // lets the last item clear the pipeline in case it caused no command.
   task wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.fan_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task csr_access(logic write, logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task set_temp_limit(int unsigned value);
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b1, CSR_DATA_W'(value), readback);
      board.set_limit(value);
      csr_access(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(board.temp_limit))
         board.report_mismatch($sformatf("temp_limit reads %0d, expected %0d", readback,
                                         board.temp_limit));
   endtask

   // Most temperatures fall near the limit or near the overheat point, where
   // the decisions change; the other sensor is cooler, equal, or swapped in.
   task pick_temps(int lim, output logic [TEMP_W-1:0] cpu, output logic [TEMP_W-1:0] gpu);
      int hottest;
      int other;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: hottest = lim - 5 + $urandom_range(0, 10);
         4, 5: hottest = $urandom_range(74, 86);
         6, 7: hottest = $urandom_range(0, 255);
         default: hottest = $urandom_range(0, lim);
      endcase
      if (hottest < 0) hottest = 0;
      if (hottest > 255) hottest = 255;
      other = ($urandom_range(0, 7) == 0) ? hottest : $urandom_range(0, hottest);
      if ($urandom_range(0, 1) == 0) begin
         cpu = TEMP_W'(hottest);
         gpu = TEMP_W'(other);
      end else begin
         cpu = TEMP_W'(other);
         gpu = TEMP_W'(hottest);
      end
   endtask

   initial begin
      int phase_limits[PHASE_COUNT];
      logic [TEMP_W-1:0] cpu;
      logic [TEMP_W-1:0] gpu;
      // Extremes of the legal range, limits below two and above eighty,
      // the usual settings, then random ones.
      phase_limits = '{2, 79, 0, 1, 100, 127, 60, 70, 75, -1, -1, -1, 65, -1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset limit of 65.
      send_item(8'd0, 8'd0);
      send_item(8'd63, 8'd63);
      send_item(8'd65, 8'd0);
      send_item(8'd0, 8'd62);
      send_item(8'd66, 8'd0);
      send_item(8'd0, 8'd79);
      send_item(8'd80, 8'd0);
      send_item(8'd255, 8'd255);
      send_item(8'd0, 8'd200);
      send_item(8'd79, 8'd1);
      send_item(8'd81, 8'd81);
      send_item(8'd0, 8'd0);
      send_item(8'd128, 8'd127);
      send_item(8'd1, 8'd2);
      send_item(8'd170, 8'd85);
      send_item(8'd64, 8'd64);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drain();
         set_temp_limit(phase_limits[p] < 0 ? $urandom_range(2, 79) : phase_limits[p]);
         idle_on <= (p != PHASE_COUNT - 1) && (p % 4 != 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick_temps(int'(board.temp_limit), cpu, gpu);
            send_item(cpu, gpu);
         end
      end

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.fail_count == 0 && board.fan_commands.size() == 0) begin
         $display("thermal_fan_speed_stepper test passed");
      end else begin
         $display("thermal_fan_speed_stepper test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("thermal_fan_speed_stepper test failed");
      $finish;
   end
endmodule
